/* rtl/mrrp_pkg.sv */
// Package: shared types, codes and the CRC-16/MODBUS byte update for the request parser.
`default_nettype none
package mrrp_pkg;

   localparam int HDR_DEPTH = 6;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [7:0] FN_READ_COILS     = 8'd1;
   localparam logic [7:0] FN_READ_INPUT_REG = 8'd4;
   localparam logic [7:0] FN_WRITE_COIL     = 8'd5;
   localparam logic [7:0] FN_WRITE_REG      = 8'd6;
   localparam logic [7:0] FN_WRITE_COILS    = 8'd15;
   localparam logic [7:0] FN_WRITE_REGS     = 8'd16;

   localparam logic [7:0] MIN_PAYLOAD_SINGLE = 8'd4;
   localparam logic [7:0] MIN_PAYLOAD_MULTI  = 8'd5;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_WRONG_SIZE = 2'd1,
      STATUS_CRC_FAIL  = 2'd2
   } status_type;

   // Frame as seen with the current (final) word included.
   typedef struct packed {
      logic                        short_frame;
      logic                        overlong;
      logic                        crc_ok;
      logic [7:0]                  payload_length;
      logic [HDR_DEPTH-1:0][7:0]   header;
   } frame_view_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  device_address;
      logic [7:0]  function_code;
      logic [15:0] reg_address;
      logic [15:0] quantity;
      logic [15:0] write_value;
      logic [7:0]  payload_length;
   } result_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

/* rtl/mrrp_frame.sv */
// Frame tracker: running CRC, word count, overlong flag and header capture.
`default_nettype none
module mrrp_frame #(
   parameter int MAX_FRAME = 256
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [7:0]            rx_byte,
   input  wire logic                  last_byte,
   output mrrp_pkg::frame_view_type   view
);
   localparam int CNT_W = $clog2(MAX_FRAME + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME);

   logic [15:0]      crc_ff, crc_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             overlong_ff, overlong_in;
   logic [mrrp_pkg::HDR_DEPTH-1:0][7:0] header_ff, header_in;
   logic [CNT_W:0]   plen_wide;

   always_comb begin
      crc_in      = mrrp_pkg::crc_byte(crc_ff, rx_byte);
      header_in   = header_ff;
      if (count_ff < CNT_W'(mrrp_pkg::HDR_DEPTH)) begin
         header_in[count_ff[2:0]] = rx_byte;
      end
      if (count_ff < MAX_CNT) begin
         count_in    = count_ff + CNT_W'(1);
         overlong_in = overlong_ff;
      end else begin
         count_in    = count_ff;
         overlong_in = 1'b1;
      end
      plen_wide = {1'b0, count_in} - (CNT_W + 1)'(4);

      view.short_frame = count_in < CNT_W'(4);
      view.overlong    = overlong_in;
      view.crc_ok      = crc_in == 16'h0000;
      view.payload_length = (plen_wide > (CNT_W + 1)'(255)) ? 8'hFF : plen_wide[7:0];
      view.header      = header_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff      <= mrrp_pkg::CRC_INIT;
         count_ff    <= '0;
         overlong_ff <= 1'b0;
      end else if (accept) begin
         if (last_byte) begin
            crc_ff      <= mrrp_pkg::CRC_INIT;
            count_ff    <= '0;
            overlong_ff <= 1'b0;
         end else begin
            crc_ff      <= crc_in;
            count_ff    <= count_in;
            overlong_ff <= overlong_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         header_ff <= header_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/mrrp_decode.sv */
// Request decoder: status and field extraction from a completed frame.
`default_nettype none
module mrrp_decode (
   input  wire mrrp_pkg::frame_view_type view,
   output mrrp_pkg::result_type          result
);
   logic [7:0]  fn;
   logic [15:0] addr_be;
   logic [15:0] word_be;

   always_comb begin
      fn      = view.header[1];
      addr_be = {view.header[2], view.header[3]};
      word_be = {view.header[4], view.header[5]};
      result  = '0;
      result.status = mrrp_pkg::STATUS_OK;
      if (view.short_frame || view.overlong) begin
         result.status = mrrp_pkg::STATUS_WRONG_SIZE;
      end else if (!view.crc_ok) begin
         result.status = mrrp_pkg::STATUS_CRC_FAIL;
      end else begin
         result.device_address = view.header[0];
         result.function_code  = fn;
         result.payload_length = view.payload_length;
         if (fn >= mrrp_pkg::FN_READ_COILS && fn <= mrrp_pkg::FN_READ_INPUT_REG) begin
            if (view.payload_length < mrrp_pkg::MIN_PAYLOAD_SINGLE) begin
               result.status = mrrp_pkg::STATUS_WRONG_SIZE;
            end else begin
               result.reg_address = addr_be;
               result.quantity    = word_be;
            end
         end else if (fn == mrrp_pkg::FN_WRITE_COIL || fn == mrrp_pkg::FN_WRITE_REG) begin
            if (view.payload_length < mrrp_pkg::MIN_PAYLOAD_SINGLE) begin
               result.status = mrrp_pkg::STATUS_WRONG_SIZE;
            end else begin
               result.reg_address = addr_be;
               result.quantity    = 16'd1;
               result.write_value = word_be;
            end
         end else if (fn == mrrp_pkg::FN_WRITE_COILS || fn == mrrp_pkg::FN_WRITE_REGS) begin
            if (view.payload_length < mrrp_pkg::MIN_PAYLOAD_MULTI) begin
               result.status = mrrp_pkg::STATUS_WRONG_SIZE;
            end else begin
               result.reg_address = addr_be;
               result.quantity    = word_be;
            end
         end
      end
   end

endmodule
`default_nettype wire

/* rtl/modbus_rtu_request_parser_unit.sv */
// Top level: Modbus RTU request parser with CRC check and a registered result word.
//
//   channel  direction  handshake         payload
//   req_     in         valid / stall     rx_byte[7:0], last_byte
//   rsp_     out        valid / stall     status, addresses, quantity, value, length
//
// One input word per cycle unless stalled; result registered on its final word.
// CRC update, count and header capture are done per word in the frame tracker.
// Reset clears CRC, count and the result valid; header bytes are not reset.
// req_stall is high only while a result is held and rsp_stall is high.
`default_nettype none
module modbus_rtu_request_parser_unit #(
   parameter int MAX_FRAME = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic        req_last_byte,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [1:0]  rsp_status,
   output      logic [7:0]  rsp_device_address,
   output      logic [7:0]  rsp_function_code,
   output      logic [15:0] rsp_reg_address,
   output      logic [15:0] rsp_quantity,
   output      logic [15:0] rsp_write_value,
   output      logic [7:0]  rsp_payload_length
);
   mrrp_pkg::frame_view_type view;
   mrrp_pkg::result_type     result_in, result_ff;
   logic                     valid_ff;
   logic                     accept;

   assign req_stall = valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   mrrp_frame #(.MAX_FRAME(MAX_FRAME)) u_frame (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_rx_byte),
      .last_byte (req_last_byte),
      .view      (view)
   );

   mrrp_decode u_decode (
      .view   (view),
      .result (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (accept && req_last_byte) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_last_byte) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_status         = result_ff.status;
   assign rsp_device_address = result_ff.device_address;
   assign rsp_function_code  = result_ff.function_code;
   assign rsp_reg_address    = result_ff.reg_address;
   assign rsp_quantity       = result_ff.quantity;
   assign rsp_write_value    = result_ff.write_value;
   assign rsp_payload_length = result_ff.payload_length;

   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_last_byte))
      else $error("result raised without a final word");

   a_crc_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == mrrp_pkg::STATUS_CRC_FAIL |->
      rsp_device_address == 8'd0 && rsp_function_code == 8'd0 &&
      rsp_payload_length == 8'd0 && rsp_quantity == 16'd0)
      else $error("crc failure carries nonzero fields");

   a_single_write_qty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == mrrp_pkg::STATUS_OK &&
      (rsp_function_code == mrrp_pkg::FN_WRITE_COIL ||
       rsp_function_code == mrrp_pkg::FN_WRITE_REG) |-> rsp_quantity == 16'd1)
      else $error("single write without quantity one");

   a_new_result_taken: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input open while result held");

endmodule
`default_nettype wire
